// File: hdl/hbc_pkg.sv
// Shared types, codes and constants of the histogram bin counter.
package hbc_pkg;

    // Fixed field widths of the request, response and configuration port.
    localparam int SAMPLE_W    = 32;
    localparam int BIN_IDX_W   = 10;
    localparam int BIN_VAL_W   = 32;
    localparam int BIN_COUNT_W = 11;
    localparam int CFG_IDX_W   = 2;
    localparam int CFG_DATA_W  = 32;
    localparam int READ_CNT_W  = 32;

    // Register indexes of the configuration port.
    localparam logic [CFG_IDX_W-1:0] CFG_LOW_EDGE  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_HIGH_EDGE = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_BIN_COUNT = 2'd2;

    // Register reset values.
    localparam logic [SAMPLE_W-1:0]    LOW_EDGE_RST  = 32'd0;
    localparam logic [SAMPLE_W-1:0]    HIGH_EDGE_RST = 32'd16777216;
    localparam logic [BIN_COUNT_W-1:0] BIN_COUNT_RST = 11'd256;

    // Request kinds.
    typedef enum logic [1:0] {
        KIND_COUNT = 2'd0,
        KIND_READ  = 2'd1,
        KIND_WRITE = 2'd2
    } kind_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic clear_step;
        logic capture;
        logic mul;
        logic div_start;
        logic lookup;
        logic inc_write;
        logic read_addr;
        logic load_out;
        logic write_val;
    } cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic  clr_last;
        logic  skip;
        logic  div_done;
        logic  in_range;
        logic  out_busy;
        kind_t req_kind;
    } sts_t;

endpackage

// File: hdl/hbc_divider.sv
// Restoring unsigned divider, one quotient bit per cycle.
module hbc_divider
    import hbc_pkg::*;
#(
    parameter int NUM_W = 44,
    parameter int DEN_W = 33
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    input  logic [NUM_W-1:0] num,
    input  logic [DEN_W-1:0] den,
    output logic             done,
    output logic [NUM_W-1:0] quot
);

    localparam int CNT_W = $clog2(NUM_W + 1);

    logic [NUM_W-1:0] quo_reg, quo_next;
    logic [DEN_W-1:0] rem_reg, rem_next;
    logic [DEN_W-1:0] den_reg, den_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic             busy_reg, busy_next;
    logic             done_reg, done_next;
    logic [DEN_W:0]   rem_sh;
    logic [DEN_W:0]   rem_sub;

    // One shift-and-subtract step on the partial remainder.
    always_comb
    begin
        rem_sh    = {rem_reg, quo_reg[NUM_W-1]};
        rem_sub   = rem_sh - {1'b0, den_reg};
        quo_next  = quo_reg;
        rem_next  = rem_reg;
        den_next  = den_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = done_reg;
        if (start)
        begin
            quo_next  = num;
            rem_next  = '0;
            den_next  = den;
            cnt_next  = CNT_W'(NUM_W);
            busy_next = 1'b1;
            done_next = 1'b0;
        end
        else if (busy_reg)
        begin
            if (rem_sh >= {1'b0, den_reg})
            begin
                rem_next = rem_sub[DEN_W-1:0];
                quo_next = {quo_reg[NUM_W-2:0], 1'b1};
            end
            else
            begin
                rem_next = rem_sh[DEN_W-1:0];
                quo_next = {quo_reg[NUM_W-2:0], 1'b0};
            end
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == CNT_W'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    // Iteration control and data registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            cnt_reg  <= cnt_next;
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        quo_reg <= quo_next;
        rem_reg <= rem_next;
        den_reg <= den_next;
    end

    assign done = done_reg;
    assign quot = quo_reg;

endmodule

// File: hdl/hbc_datapath.sv
// Datapath: configuration registers, bin scaling, counter memory and response register.
module hbc_datapath
    import hbc_pkg::*;
#(
    parameter int MAX_BINS   = 1024,
    parameter int COUNT_BITS = 32
)
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   cfg_wr_en,
    input  logic [CFG_IDX_W-1:0]   cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_data,
    input  logic [1:0]             kind,
    input  logic [SAMPLE_W-1:0]    sample,
    input  logic [BIN_IDX_W-1:0]   bin_index,
    input  logic [BIN_VAL_W-1:0]   bin_value,
    input  logic                   rsp_stall,
    output logic                   rsp_valid,
    output logic [BIN_IDX_W-1:0]   read_index,
    output logic [READ_CNT_W-1:0]  read_count,
    input  cmd_t                   cmd,
    output sts_t                   sts
);

    localparam int AW = $clog2(MAX_BINS);
    localparam int BW = $clog2(MAX_BINS + 1);
    localparam int DW = SAMPLE_W + 1;
    localparam int NW = DW + BW;

    // Configuration registers.
    logic [SAMPLE_W-1:0]    low_edge_reg;
    logic [SAMPLE_W-1:0]    high_edge_reg;
    logic [BIN_COUNT_W-1:0] bin_count_reg;

    // Captured request.
    logic [SAMPLE_W-1:0]  sample_reg;
    logic [BIN_IDX_W-1:0] idx_reg;
    logic [BIN_VAL_W-1:0] val_reg;

    // Scaling stage.
    logic signed [NW-1:0] prod_reg, prod_next;
    logic signed [DW-1:0] range_reg, range_next;
    logic                 skip_reg, skip_next;
    logic                 neg_reg, neg_next;
    logic signed [DW-1:0] diff;
    logic signed [NW-1:0] diff_w;
    logic signed [NW-1:0] bins_w;
    logic [31:0]          bc_ext;
    logic [BW-1:0]        bins_eff;

    // Divider connections.
    logic [NW-1:0] num_mag;
    logic [DW-1:0] den_mag;
    logic [NW-1:0] quot;
    logic          div_done;

    // Memory and clearing pass.
    logic [COUNT_BITS-1:0] mem [MAX_BINS];
    logic [COUNT_BITS-1:0] rd_data_reg;
    logic [AW-1:0]         clr_addr_reg, clr_addr_next;
    logic [AW-1:0]         q_addr;
    logic [AW-1:0]         idx_addr;
    logic [AW-1:0]         wr_addr;
    logic [AW-1:0]         rd_addr;
    logic [COUNT_BITS-1:0] wr_data;
    logic                  wr_en;
    logic                  rd_en;
    logic [31:0]           idx_ext;
    logic                  idx_ok;
    logic [63:0]           val_ext;
    logic [63:0]           rd_ext;
    logic                  in_range;

    // Response register.
    logic                  out_valid_reg, out_valid_next;
    logic [BIN_IDX_W-1:0]  read_index_reg;
    logic [READ_CNT_W-1:0] read_count_reg;

    // Configuration writes.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            low_edge_reg  <= LOW_EDGE_RST;
            high_edge_reg <= HIGH_EDGE_RST;
            bin_count_reg <= BIN_COUNT_RST;
        end
        else if (cfg_wr_en)
        begin
            unique case (cfg_index)
                CFG_LOW_EDGE:  low_edge_reg  <= cfg_data;
                CFG_HIGH_EDGE: high_edge_reg <= cfg_data;
                CFG_BIN_COUNT: bin_count_reg <= cfg_data[BIN_COUNT_W-1:0];
                default:       ;
            endcase
        end
    end

    // Request capture.
    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            sample_reg <= sample;
            idx_reg    <= bin_index;
            val_reg    <= bin_value;
        end
    end

    // Bin count in use, limited to the store depth.
    always_comb
    begin
        bc_ext = 32'(bin_count_reg);
        if (bc_ext > 32'(MAX_BINS))
            bins_eff = BW'(MAX_BINS);
        else
            bins_eff = bc_ext[BW-1:0];
    end

    // Scaling: (sample - low) * bins, and the range high - low.
    always_comb
    begin
        diff       = DW'(signed'(sample_reg)) - DW'(signed'(low_edge_reg));
        diff_w     = NW'(diff);
        bins_w     = signed'(NW'(bins_eff));
        prod_next  = prod_reg;
        range_next = range_reg;
        skip_next  = skip_reg;
        neg_next   = neg_reg;
        if (cmd.mul)
        begin
            prod_next  = diff_w * bins_w;
            range_next = DW'(signed'(high_edge_reg)) - DW'(signed'(low_edge_reg));
            skip_next  = (range_next == '0) || (bins_eff == '0);
            neg_next   = prod_next[NW-1] ^ range_next[DW-1];
        end
    end

    always_ff @(posedge clk)
    begin
        prod_reg  <= prod_next;
        range_reg <= range_next;
        skip_reg  <= skip_next;
        neg_reg   <= neg_next;
    end

    // Magnitudes for the unsigned divider.
    assign num_mag = prod_reg[NW-1] ? NW'(-prod_reg) : NW'(prod_reg);
    assign den_mag = range_reg[DW-1] ? DW'(-range_reg) : DW'(range_reg);

    hbc_divider #(
        .NUM_W (NW),
        .DEN_W (DW)
    ) u_divider (
        .clk   (clk),
        .rst_n (rst_n),
        .start (cmd.div_start),
        .num   (num_mag),
        .den   (den_mag),
        .done  (div_done),
        .quot  (quot)
    );

    // A zero quotient is bin 0 whatever its sign; otherwise it must be positive and below bins.
    assign in_range = (quot == '0) || (!neg_reg && (quot < NW'(bins_eff)));
    assign q_addr   = quot[AW-1:0];

    // Address checks for reads and writes.
    assign idx_ext  = 32'(idx_reg);
    assign idx_ok   = idx_ext < 32'(MAX_BINS);
    assign idx_addr = idx_ext[AW-1:0];
    assign val_ext  = 64'(val_reg);
    assign rd_ext   = 64'(rd_data_reg);

    // Clearing pass address.
    assign clr_addr_next = cmd.clear_step ? clr_addr_reg + 1'b1 : clr_addr_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            clr_addr_reg <= '0;
        else
            clr_addr_reg <= clr_addr_next;
    end

    // Memory port selection.
    always_comb
    begin
        wr_en   = 1'b0;
        wr_addr = clr_addr_reg;
        wr_data = '0;
        priority if (cmd.clear_step)
        begin
            wr_en = 1'b1;
        end
        else if (cmd.inc_write)
        begin
            wr_en   = 1'b1;
            wr_addr = q_addr;
            wr_data = (rd_data_reg == '1) ? rd_data_reg : rd_data_reg + 1'b1;
        end
        else if (cmd.write_val)
        begin
            wr_en   = idx_ok;
            wr_addr = idx_addr;
            wr_data = val_ext[COUNT_BITS-1:0];
        end
        rd_en   = cmd.lookup || cmd.read_addr;
        rd_addr = cmd.lookup ? q_addr : idx_addr;
    end

    // Counter memory with registered read data.
    always_ff @(posedge clk)
    begin
        if (wr_en)
            mem[wr_addr] <= wr_data;
        if (rd_en)
            rd_data_reg <= mem[rd_addr];
    end

    // Response register: loaded by a read, freed when the receiver takes it.
    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (out_valid_reg && !rsp_stall)
            out_valid_next = 1'b0;
        if (cmd.load_out)
            out_valid_next = 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else
            out_valid_reg <= out_valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load_out)
        begin
            read_index_reg <= idx_reg;
            read_count_reg <= idx_ok ? rd_ext[READ_CNT_W-1:0] : '0;
        end
    end

    assign rsp_valid  = out_valid_reg;
    assign read_index = read_index_reg;
    assign read_count = read_count_reg;

    // Status to the controller.
    always_comb
    begin
        sts.clr_last = clr_addr_reg == AW'(MAX_BINS - 1);
        sts.skip     = skip_reg;
        sts.div_done = div_done;
        sts.in_range = in_range;
        sts.out_busy = out_valid_reg;
        sts.req_kind = kind_t'(kind);
    end

endmodule

// File: hdl/hbc_ctrl.sv
// Controller state machine: sequences clearing, counting, reads and writes.
module hbc_ctrl
    import hbc_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic req_valid,
    output logic req_stall,
    input  sts_t sts,
    output cmd_t cmd
);

    typedef enum logic [9:0] {
        ST_CLEAR     = 10'b00_0000_0001,
        ST_IDLE      = 10'b00_0000_0010,
        ST_MUL       = 10'b00_0000_0100,
        ST_DIV_START = 10'b00_0000_1000,
        ST_DIV_WAIT  = 10'b00_0001_0000,
        ST_LOOKUP    = 10'b00_0010_0000,
        ST_INC       = 10'b00_0100_0000,
        ST_RD_ADDR   = 10'b00_1000_0000,
        ST_RD_DATA   = 10'b01_0000_0000,
        ST_WR        = 10'b10_0000_0000
    } state_t;

    state_t state_reg, state_next;
    logic   req_accept;

    // A read waits while an earlier response still sits in the output register.
    assign req_stall  = (state_reg != ST_IDLE) ||
                        (sts.out_busy && (sts.req_kind == KIND_READ));
    assign req_accept = req_valid && !req_stall;

    // Next state and commands.
    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        unique case (state_reg)
            ST_CLEAR:
            begin
                cmd.clear_step = 1'b1;
                if (sts.clr_last)
                    state_next = ST_IDLE;
            end
            ST_IDLE:
            begin
                if (req_accept)
                begin
                    cmd.capture = 1'b1;
                    unique case (sts.req_kind)
                        KIND_COUNT: state_next = ST_MUL;
                        KIND_READ:  state_next = ST_RD_ADDR;
                        KIND_WRITE: state_next = ST_WR;
                        default:    state_next = ST_IDLE;
                    endcase
                end
            end
            ST_MUL:
            begin
                cmd.mul    = 1'b1;
                state_next = ST_DIV_START;
            end
            ST_DIV_START:
            begin
                if (sts.skip)
                    state_next = ST_IDLE;
                else
                begin
                    cmd.div_start = 1'b1;
                    state_next    = ST_DIV_WAIT;
                end
            end
            ST_DIV_WAIT:
            begin
                if (sts.div_done)
                    state_next = ST_LOOKUP;
            end
            ST_LOOKUP:
            begin
                cmd.lookup = 1'b1;
                state_next = sts.in_range ? ST_INC : ST_IDLE;
            end
            ST_INC:
            begin
                cmd.inc_write = 1'b1;
                state_next    = ST_IDLE;
            end
            ST_RD_ADDR:
            begin
                cmd.read_addr = 1'b1;
                state_next    = ST_RD_DATA;
            end
            ST_RD_DATA:
            begin
                cmd.load_out = 1'b1;
                state_next   = ST_IDLE;
            end
            ST_WR:
            begin
                cmd.write_val = 1'b1;
                state_next    = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // State register; reset starts the clearing pass.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= ST_CLEAR;
        else
            state_reg <= state_next;
    end

`ifndef ASSERT_OFF
    // A counter is only incremented after a lookup that found the bin in range.
    a_inc_after_hit: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_INC) |-> ($past(state_reg) == ST_LOOKUP) && $past(sts.in_range))
        else $error("increment without an in-range lookup");

    // The quotient is complete whenever the lookup uses it.
    a_lookup_div_done: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_LOOKUP) |-> sts.div_done)
        else $error("lookup before the divider finished");

    // A read response never overwrites one that has not been taken.
    a_load_out_free: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.load_out |-> !sts.out_busy)
        else $error("response register loaded while occupied");
`endif

endmodule

// File: hdl/histogram_bin_counter_top.sv
// Top level of the histogram bin counter: controller and datapath.
//
// Usage:
//   Requests enter on req_valid/req_stall with kind, sample, bin_index and
//   bin_value. Kind count bins a Q16.16 sample between low_edge and high_edge
//   into bin_count uniform bins and increments that saturating counter; kind
//   read returns read_index/read_count on rsp_valid/rsp_stall; kind write
//   preloads a counter. Configuration is written through cfg_wr_en,
//   cfg_index and cfg_data while no request is in progress.
//   Requests are handled one at a time. A count request steps through the
//   multiply, divider start, divider wait, lookup and increment states, paced
//   by the one-bit-per-cycle divider and ending early for an empty range, no
//   bins or a sample outside them; a read request steps through the address
//   and data states, and a write through the write state. After reset the
//   block clears the counter memory, one entry per cycle, while req_stall
//   stays high. A response waits in the output register while rsp_stall is
//   high; count and write requests are still accepted meanwhile, and only
//   the next read request is held off until the response is taken.
module histogram_bin_counter_top
    import hbc_pkg::*;
#(
    parameter int MAX_BINS   = 1024,
    parameter int COUNT_BITS = 32
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_wr_en,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    input  logic                  req_valid,
    output logic                  req_stall,
    input  logic [1:0]            kind,
    input  logic [SAMPLE_W-1:0]   sample,
    input  logic [BIN_IDX_W-1:0]  bin_index,
    input  logic [BIN_VAL_W-1:0]  bin_value,
    output logic                  rsp_valid,
    input  logic                  rsp_stall,
    output logic [BIN_IDX_W-1:0]  read_index,
    output logic [READ_CNT_W-1:0] read_count
);

    cmd_t cmd;
    sts_t sts;

    // Sequencing.
    hbc_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .sts       (sts),
        .cmd       (cmd)
    );

    // Arithmetic, storage and response register.
    hbc_datapath #(
        .MAX_BINS   (MAX_BINS),
        .COUNT_BITS (COUNT_BITS)
    ) u_datapath (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_wr_en  (cfg_wr_en),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .kind       (kind),
        .sample     (sample),
        .bin_index  (bin_index),
        .bin_value  (bin_value),
        .rsp_stall  (rsp_stall),
        .rsp_valid  (rsp_valid),
        .read_index (read_index),
        .read_count (read_count),
        .cmd        (cmd),
        .sts        (sts)
    );

endmodule

// File: bench/tb_top.sv
// Self-checking bench for the histogram bin counter: a directed table, then randomized phases.
module tb_top;
    import hbc_pkg::*;

    localparam int NUM_BINS    = 1024;
    localparam int SETTLE      = 64;     // long enough for a count request to finish
    localparam int QUIET_LIMIT = 4096;   // covers the memory clear after reset and a config pause
    localparam int PHASES      = 10;
    localparam int PHASE_ITEMS = 113;

    // Codes the package leaves unnamed: the unused request kind and register index.
    localparam logic [1:0]           KIND_SPARE = 2'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE  = 2'd3;

    // One expected read response.
    typedef struct packed {
        logic [BIN_IDX_W-1:0]  index;
        logic [READ_CNT_W-1:0] count;
    } read_rsp_t;

    // One row of the directed table: a register write or a request.
    typedef struct packed {
        logic                  cfg;
        logic [1:0]            code;
        logic [31:0]           data;
        logic [BIN_IDX_W-1:0]  idx;
        logic [BIN_VAL_W-1:0]  val;
        logic                  typed;
        logic [READ_CNT_W-1:0] count;
    } step_t;

    logic                  clk = 1'b0;
    logic                  rst_n;
    logic                  cfg_wr_en;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;
    logic                  req_valid;
    logic                  req_stall;
    logic [1:0]            kind;
    logic [SAMPLE_W-1:0]   sample;
    logic [BIN_IDX_W-1:0]  bin_index;
    logic [BIN_VAL_W-1:0]  bin_value;
    logic                  rsp_valid;
    logic                  rsp_stall;
    logic [BIN_IDX_W-1:0]  read_index;
    logic [READ_CNT_W-1:0] read_count;

    // Shadow copy of the block's registers and counter store.
    int                    edge_lo;
    int                    edge_hi;
    logic [10:0]           bins_cfg;
    logic [31:0]           counters [NUM_BINS];
    read_rsp_t             pending_reads [$];

    int                    mismatches   = 0;
    int                    quiet_cycles = 0;
    bit                    req_steady   = 1'b0;
    bit                    rsp_steady   = 1'b0;

    histogram_bin_counter_top u_top (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_wr_en  (cfg_wr_en),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .req_valid  (req_valid),
        .req_stall  (req_stall),
        .kind       (kind),
        .sample     (sample),
        .bin_index  (bin_index),
        .bin_value  (bin_value),
        .rsp_valid  (rsp_valid),
        .rsp_stall  (rsp_stall),
        .read_index (read_index),
        .read_count (read_count)
    );

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    // Bins actually in use: the register value, capped at the store depth.
    function automatic longint bins_in_use();
        return (bins_cfg > NUM_BINS) ? NUM_BINS : longint'(bins_cfg);
    endfunction

    // Bin a sample and bump its saturating counter when it lands inside the range.
    function automatic void bin_sample(int s);
        longint span;
        longint used;
        longint slot;
        span = longint'(edge_hi) - longint'(edge_lo);
        used = bins_in_use();
        if (span != 0 && used != 0)
        begin
            slot = ((longint'(s) - longint'(edge_lo)) * used) / span;
            if (slot >= 0 && slot < used && counters[slot] != '1)
                counters[slot] = counters[slot] + 1;
        end
    endfunction

    // Sample at the middle of a given bin under the current edges.
    function automatic int aim_at(longint slot);
        longint used;
        longint span;
        used = bins_in_use();
        if (used == 0)
            used = 1;
        span = longint'(edge_hi) - longint'(edge_lo);
        return int'(longint'(edge_lo) + ((2 * slot + 1) * span) / (2 * used));
    endfunction

    // Write a register once the block has gone quiet.
    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [31:0] data);
        req_valid <= 1'b0;
        while (pending_reads.size() != 0)
            @(negedge clk);
        repeat (SETTLE) @(negedge clk);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(negedge clk);
        cfg_wr_en <= 1'b0;
        case (idx)
            CFG_LOW_EDGE:  edge_lo = data;
            CFG_HIGH_EDGE: edge_hi = data;
            CFG_BIN_COUNT: bins_cfg = data[10:0];
            default: ;
        endcase
    endtask

    // Issue one request after a random gap and record its effect once accepted.
    task automatic send_request(logic [1:0] k, logic [31:0] smp, logic [BIN_IDX_W-1:0] bi,
                                logic [31:0] bv, logic typed, logic [31:0] typed_count);
        int unsigned gap;
        read_rsp_t   rsp;
        gap = req_steady ? 0 : $urandom_range(0, 13);
        if (gap != 0)
        begin
            req_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        req_valid <= 1'b1;
        kind      <= k;
        sample    <= smp;
        bin_index <= bi;
        bin_value <= bv;
        do
            @(posedge clk);
        while (req_stall);
        case (k)
            KIND_COUNT: bin_sample(smp);
            KIND_READ:
            begin
                rsp.index = bi;
                rsp.count = typed ? typed_count : counters[bi];
                pending_reads.push_back(rsp);
            end
            KIND_WRITE: counters[bi] = bv;
            default: ;
        endcase
        @(negedge clk);
    endtask

    // Request stimulus: reset, directed table, then randomized configuration phases.
    initial
    begin : stimulus
        step_t       plan [26];
        logic [1:0]  k;
        logic [31:0] smp;
        logic [31:0] bv;
        logic [31:0] lo;
        logic [31:0] hi;
        logic [31:0] nb;
        logic [9:0]  bi;
        int unsigned pick;
        int unsigned sel;
        longint      focus;
        longint      used;

        rst_n     = 1'b0;
        cfg_wr_en = 1'b0;
        cfg_index = CFG_LOW_EDGE;
        cfg_data  = '0;
        req_valid = 1'b0;
        kind      = KIND_COUNT;
        sample    = '0;
        bin_index = '0;
        bin_value = '0;
        edge_lo   = LOW_EDGE_RST;
        edge_hi   = HIGH_EDGE_RST;
        bins_cfg  = BIN_COUNT_RST;
        foreach (counters[i])
            counters[i] = '0;

        // With reset edges and 256 bins, the bin is the integer part of the sample.
        plan = '{
            '{1'b0, KIND_READ,     32'h0,        10'd0,    32'h0,        1'b1, 32'd0},
            '{1'b0, KIND_READ,     32'h0,        10'd1023, 32'h0,        1'b1, 32'd0},
            '{1'b0, KIND_COUNT,    32'h00000000, 10'd0,    32'h0,        1'b0, 32'd0},
            '{1'b0, KIND_COUNT,    32'h0000FFFF, 10'd0,    32'h0,        1'b0, 32'd0},
            // Half a bin below the low edge truncates into bin 0.
            '{1'b0, KIND_COUNT,    32'hFFFF8000, 10'd0,    32'h0,        1'b0, 32'd0},
            '{1'b0, KIND_READ,     32'h0,        10'd0,    32'h0,        1'b1, 32'd3},
            '{1'b0, KIND_COUNT,    32'h00FFFFFF, 10'd0,    32'h0,        1'b0, 32'd0},
            '{1'b0, KIND_COUNT,    32'h01000000, 10'd0,    32'h0,        1'b0, 32'd0},
            '{1'b0, KIND_COUNT,    32'h80000000, 10'd0,    32'h0,        1'b0, 32'd0},
            '{1'b0, KIND_COUNT,    32'h7FFFFFFF, 10'd0,    32'h0,        1'b0, 32'd0},
            '{1'b0, KIND_READ,     32'h0,        10'd255,  32'h0,        1'b1, 32'd1},
            // A full counter stays full.
            '{1'b0, KIND_WRITE,    32'h0,        10'd5,    32'hFFFFFFFF, 1'b0, 32'd0},
            '{1'b0, KIND_COUNT,    32'h00058000, 10'd0,    32'h0,        1'b0, 32'd0},
            '{1'b0, KIND_READ,     32'h0,        10'd5,    32'h0,        1'b1, 32'hFFFFFFFF},
            '{1'b0, KIND_WRITE,    32'h0,        10'd1023, 32'h5A5AA5A5, 1'b0, 32'd0},
            '{1'b0, KIND_READ,     32'h0,        10'd1023, 32'h0,        1'b1, 32'h5A5AA5A5},
            '{1'b0, KIND_SPARE,    32'hFFFFFFFF, 10'd1023, 32'hFFFFFFFF, 1'b0, 32'd0},
            // Equal edges count nothing.
            '{1'b1, CFG_HIGH_EDGE, 32'h00000000, 10'd0,    32'h0,        1'b0, 32'd0},
            '{1'b0, KIND_COUNT,    32'h00000000, 10'd0,    32'h0,        1'b0, 32'd0},
            '{1'b0, KIND_READ,     32'h0,        10'd0,    32'h0,        1'b1, 32'd3},
            // Reversed edges with a bin count above the store depth.
            '{1'b1, CFG_HIGH_EDGE, 32'h00010000, 10'd0,    32'h0,        1'b0, 32'd0},
            '{1'b1, CFG_LOW_EDGE,  32'h00020000, 10'd0,    32'h0,        1'b0, 32'd0},
            '{1'b1, CFG_BIN_COUNT, 32'hFFFFFFFF, 10'd0,    32'h0,        1'b0, 32'd0},
            '{1'b0, KIND_COUNT,    32'h00018000, 10'd0,    32'h0,        1'b0, 32'd0},
            '{1'b0, KIND_READ,     32'h0,        10'd512,  32'h0,        1'b0, 32'd0},
            '{1'b1, CFG_SPARE,     32'hA5A5A5A5, 10'd0,    32'h0,        1'b0, 32'd0}
        };

        repeat (8) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        foreach (plan[i])
        begin
            if (plan[i].cfg)
                write_reg(plan[i].code, plan[i].data);
            else
                send_request(plan[i].code, plan[i].data, plan[i].idx, plan[i].val,
                             plan[i].typed, plan[i].count);
        end

        // Each phase sets all three registers, then streams random requests.
        for (int p = 0; p < PHASES; p++)
        begin
            case (p)
                0:
                begin
                    lo = 32'h80000000; hi = 32'h7FFFFFFF; nb = 32'd1024;
                end
                1:
                begin
                    lo = 32'hFFF60000; hi = 32'h000A0000; nb = 32'd20;
                end
                2:
                begin
                    lo = 32'h00050000; hi = 32'h00050000; nb = 32'd8;
                end
                3:
                begin
                    lo = 32'h00640000; hi = 32'hFFCE0000; nb = 32'd15;
                end
                4:
                begin
                    lo = 32'h00000000; hi = 32'h00010000; nb = 32'd0;
                end
                5:
                begin
                    lo = 32'hFFFF0000; hi = 32'h00010000; nb = {21'($urandom), 11'h7FF};
                end
                6:
                begin
                    lo = 32'h00000000; hi = 32'h00000002; nb = 32'd1;
                end
                7:
                begin
                    lo = 32'h7FFFFFFF; hi = 32'h80000000; nb = 32'd1024;
                end
                default:
                begin
                    lo = $urandom; hi = $urandom; nb = $urandom_range(1, NUM_BINS);
                end
            endcase
            write_reg(CFG_LOW_EDGE, lo);
            write_reg(CFG_HIGH_EDGE, hi);
            write_reg(CFG_BIN_COUNT, nb);

            used = bins_in_use();
            if (used == 0)
                used = 1;
            focus = $urandom_range(0, used - 1);

            for (int n = 0; n < PHASE_ITEMS; n++)
            begin
                if ($urandom_range(0, 39) == 0)
                    req_steady = !req_steady;
                if ($urandom_range(0, 15) == 0)
                    focus = $urandom_range(0, used - 1);
                k    = KIND_COUNT;
                smp  = $urandom;
                bi   = $urandom_range(0, NUM_BINS - 1);
                bv   = $urandom;
                pick = $urandom_range(0, 99);
                if (pick < 50)
                begin
                    // Mostly samples aimed at real bins, some just below the low edge, the rest random.
                    sel = $urandom_range(0, 9);
                    if (sel < 4)
                        smp = aim_at(focus) + $urandom_range(0, 6) - 3;
                    else if (sel < 7)
                        smp = aim_at($urandom_range(0, used - 1));
                    else if (sel < 8)
                        smp = edge_lo - $urandom_range(0, 70000);
                end
                else if (pick < 75)
                begin
                    k = KIND_READ;
                    if ($urandom_range(0, 1) == 1)
                        bi = 10'(focus);
                end
                else if (pick < 95)
                begin
                    // Preloads near the top let the counts run into saturation.
                    k = KIND_WRITE;
                    if ($urandom_range(0, 1) == 1)
                        bi = 10'(focus);
                    if ($urandom_range(0, 2) == 0)
                        bv = 32'hFFFFFFFF - $urandom_range(0, 3);
                end
                else
                    k = KIND_SPARE;
                send_request(k, smp, bi, bv, 1'b0, '0);
            end
        end

        // Drain outstanding reads, then watch for stray responses.
        req_valid <= 1'b0;
        while (pending_reads.size() != 0)
            @(negedge clk);
        repeat (SETTLE) @(negedge clk);
        if (mismatches == 0 && pending_reads.size() == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

    // Response side: hold each response for a random number of cycles.
    initial
    begin : rsp_side
        int unsigned hold;
        rsp_stall = 1'b0;
        forever
        begin
            @(negedge clk);
            if ($urandom_range(0, 29) == 0)
                rsp_steady = !rsp_steady;
            hold = rsp_steady ? 0 : $urandom_range(0, 13);
            rsp_stall <= (hold != 0);
            do
                @(posedge clk);
            while (rsp_valid !== 1'b1);
            if (hold != 0)
            begin
                repeat (hold) @(negedge clk);
                rsp_stall <= 1'b0;
                do
                    @(posedge clk);
                while (rsp_valid !== 1'b1);
            end
        end
    end

    // Compare every accepted response with the oldest outstanding read.
    always @(posedge clk)
    begin : check_rsp
        read_rsp_t want;
        if (rst_n && rsp_valid && !rsp_stall)
        begin
            if (pending_reads.size() == 0)
            begin
                $error("response with no read outstanding: read_index %0d read_count %0h",
                       read_index, read_count);
                mismatches++;
            end
            else
            begin
                want = pending_reads.pop_front();
                if (read_index !== want.index)
                begin
                    $error("read_index: expected %0d, got %0d", want.index, read_index);
                    mismatches++;
                end
                if (read_count !== want.count)
                begin
                    $error("read_count: expected %0h, got %0h", want.count, read_count);
                    mismatches++;
                end
            end
        end
    end

    // Watchdog on cycles in which nothing moves on any port.
    always @(posedge clk)
    begin
        if (!rst_n || (req_valid && !req_stall) || (rsp_valid && !rsp_stall) || cfg_wr_en)
            quiet_cycles <= 0;
        else if (quiet_cycles >= QUIET_LIMIT)
        begin
            $display("== FAIL ==");
            $finish;
        end
        else
            quiet_cycles <= quiet_cycles + 1;
    end

endmodule
